@@ rtl/core/itoa_pkg.sv @@
// Shared constants, types and helper functions for the integer to radix ASCII converter.
package itoa_pkg;

   localparam int VALUE_BITS    = 31;
   localparam int RADIX_W       = 5;
   localparam int DIGIT_W       = 4;
   localparam int CHAR_W        = 7;
   localparam int BITS_PER_STEP = 8;
   localparam int DIV_CYCLES    = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int DIV_BITS      = DIV_CYCLES * BITS_PER_STEP;
   localparam int STEP_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int MAX_DIGITS    = VALUE_BITS;
   localparam int PTR_W         = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W         = $clog2(MAX_DIGITS);

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);
   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = CHAR_W'(8'h41);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } itoa_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic pop;
   } itoa_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic quot_zero;
      logic stack_last;
   } itoa_sts_type;

   function automatic logic [RADIX_W-1:0] saturate_radix(input logic [RADIX_W-1:0] raw);
      logic [RADIX_W-1:0] r;
      r = raw;
      if (raw < RADIX_MIN) begin
         r = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
         r = RADIX_MAX;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_TEN) begin
         c = ASCII_ZERO + CHAR_W'(d);
      end else begin
         c = ASCII_UPPER_A + CHAR_W'(d - DIGIT_TEN);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/itoa_ctrl.sv @@
// Controller state machine that sequences the division passes and digit emission.
module itoa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  itoa_pkg::itoa_sts_type sts,
   output itoa_pkg::itoa_cmd_type cmd
);
   import itoa_pkg::*;

   itoa_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_cnt_ff, step_cnt_in;
   logic              step_last;

   assign step_last = (step_cnt_ff == STEP_W'(DIV_CYCLES - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (step_last && sts.quot_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.stack_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cmd.push     = step_last;
         end
         ST_EMIT: begin
            cmd.pop = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // The step counter walks through the cycles of one division pass.
   always_comb begin
      step_cnt_in = step_cnt_ff;
      if (cmd.load || (cmd.div_step && step_last)) begin
         step_cnt_in = '0;
      end else if (cmd.div_step) begin
         step_cnt_in = step_cnt_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

endmodule

@@ rtl/core/itoa_dpath.sv @@
// Datapath: radix register, shared small-divisor divider, digit stack and result register.
module itoa_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [itoa_pkg::RADIX_W-1:0]        csr_write_data,
   input  logic [itoa_pkg::VALUE_BITS-1:0]     req_value,
   input  itoa_pkg::itoa_cmd_type              cmd,
   output itoa_pkg::itoa_sts_type              sts,
   output logic                                rsp_valid,
   output logic [itoa_pkg::CHAR_W-1:0]         rsp_digit_char,
   output logic                                rsp_last
);
   import itoa_pkg::*;

   logic [RADIX_W-1:0]  radix_ff, radix_in;
   logic [DIV_BITS-1:0] div_ff, div_in, div_v;
   logic [DIGIT_W-1:0]  rem_ff, rem_in, rem_v;
   logic [RADIX_W-1:0]  trial, diff;
   logic                ge;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [IDX_W-1:0]    pop_idx;
   logic [DIGIT_W-1:0]  digits_ff [MAX_DIGITS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic                rsp_last_ff, rsp_last_in;

   // The radix is stored already clamped to its legal range.
   assign radix_in = csr_write_en ? saturate_radix(csr_write_data) : radix_ff;

   // Eight restoring division steps per cycle; the remainder never reaches the radix.
   always_comb begin
      rem_v = rem_ff;
      div_v = div_ff;
      trial = '0;
      diff  = '0;
      ge    = 1'b0;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial = {rem_v, div_v[DIV_BITS-1]};
         ge    = (trial >= radix_ff);
         diff  = trial - radix_ff;
         rem_v = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         div_v = {div_v[DIV_BITS-2:0], ge};
      end
   end

   always_comb begin
      div_in = div_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         div_in = DIV_BITS'(req_value);
         rem_in = '0;
      end else if (cmd.div_step) begin
         div_in = div_v;
         rem_in = cmd.push ? '0 : rem_v;
      end
   end

   assign pop_idx = IDX_W'(ptr_ff - PTR_W'(1));

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.push) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end else if (cmd.pop) begin
         ptr_in = ptr_ff - PTR_W'(1);
      end
   end

   assign sts.quot_zero  = (div_v == '0);
   assign sts.stack_last = (ptr_ff == PTR_W'(1));

   assign rsp_valid_in = cmd.pop;
   assign rsp_last_in  = sts.stack_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      if (cmd.push) begin
         digits_ff[ptr_ff[IDX_W-1:0]] <= rem_v;
      end
      if (cmd.pop) begin
         rsp_char_ff <= digit_to_ascii(digits_ff[pop_idx]);
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ rtl/core/integer_to_radix_ascii_digits_core.sv @@
// Top level of the integer to radix ASCII digit converter.
//
//   Channel   Ports                                      Handshake
//   request   start, busy, req_value[30:0]               taken when start && !busy
//   response  rsp_valid, rsp_digit_char[6:0], rsp_last   one-cycle strobe, never held off
//   config    csr_write_en, csr_write_data[4:0]          written when csr_write_en is high
//
// Each digit of an item costs one division pass (eight quotient bits per cycle
// through the shared divider), and the stacked digits are then popped one per cycle;
// busy stays high until the last pop. Digits appear on the result ports in the cycle
// after each pop, most significant first.
// Synchronous reset clears the controller, the digit stack pointer and the strobe,
// and sets the radix to ten. Results cannot be stalled, so nothing waits on the receiver.
module integer_to_radix_ascii_digits_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [itoa_pkg::VALUE_BITS-1:0]  req_value,
   output logic                             rsp_valid,
   output logic [itoa_pkg::CHAR_W-1:0]      rsp_digit_char,
   output logic                             rsp_last,
   input  logic                             csr_write_en,
   input  logic [itoa_pkg::RADIX_W-1:0]     csr_write_data
);
   import itoa_pkg::*;

   itoa_cmd_type cmd;
   itoa_sts_type sts;

   // The controller decides when to load, divide, push and pop; it holds the
   // step counter and the state only.
   itoa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // The datapath computes digits least significant first and stacks them,
   // so popping the stack yields them in printing order.
   itoa_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_value      (req_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   // A digit only follows a cycle in which the block was working.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("digit strobe without preceding busy cycle");

   // An accepted item makes the block busy once the controller leaves idle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Nothing follows the final digit of an item directly.
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("digit strobe directly after the final digit");

endmodule
